### src/ps2_mouse_packet_decoder_top_macros.svh
// Assertion helpers for the mouse packet decoder.
// Both forms sample on clk_i and are off while rst_ni is low.
`ifndef PS2_MOUSE_PACKET_DECODER_TOP_MACROS_SVH
`define PS2_MOUSE_PACKET_DECODER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication
`define PMPD_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pmpd: same-cycle check failed");
// next-cycle implication
`define PMPD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pmpd: next-cycle check failed");
`else
`define PMPD_ASSERT_SAME(lbl, ante, cons)
`define PMPD_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

### src/pmpd_pkg.sv
package pmpd_pkg;

  localparam int unsigned PositionBits = 12;
  localparam int unsigned CfgW         = 13;
  localparam int unsigned CfgIdxW      = 2;
  localparam int unsigned InDataW      = 40;  // data_byte, set_x, set_y
  localparam int unsigned QDepth       = 2;

  localparam logic [12:0] ResetWidth   = 13'd1024;
  localparam logic [12:0] ResetHeight  = 13'd768;
  localparam logic [2:0]  ResetPktSize = 3'd3;
  localparam logic [2:0]  PktSizeWheel = 3'd4;
  localparam int unsigned CursorXReset = 512;
  localparam int unsigned CursorYReset = 384;

  typedef enum logic [1:0] {
    CFG_SCREEN_WIDTH  = 2'd0,
    CFG_SCREEN_HEIGHT = 2'd1,
    CFG_PACKET_SIZE   = 2'd2
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ACT_MOTION = 2'd0,
    ACT_LEFT   = 2'd1,
    ACT_RIGHT  = 2'd2,
    ACT_MIDDLE = 2'd3
  } action_e;

  typedef enum logic {
    CMD_DATA   = 1'b0,
    CMD_SETPOS = 1'b1
  } cmd_e;

  typedef enum logic {
    JOB_SETPOS = 1'b0,
    JOB_PACKET = 1'b1
  } job_kind_e;

  typedef struct packed {
    logic [12:0] screen_width;
    logic [12:0] screen_height;
    logic [2:0]  packet_size;
  } cfg_t;

  // one queue entry: either a cursor load or a decoded packet
  typedef struct packed {
    job_kind_e          kind;
    logic signed [15:0] set_x;
    logic signed [15:0] set_y;
    logic signed [10:0] rel_x;
    logic signed [10:0] rel_y;
    logic signed [3:0]  rel_z;
    logic [2:0]         btn;
  } job_t;

endpackage

### src/pmpd_front.sv
module pmpd_front (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              in_cmd_i,
  input  logic [pmpd_pkg::InDataW-1:0]      in_data_i,
  input  logic                              wheel_i,
  input  logic                              q_full_i,
  output logic                              push_o,
  output pmpd_pkg::job_t                    job_o
);
  import pmpd_pkg::*;

  logic [1:0] idx_q, idx_d;
  logic [7:0] bytes_q [3];

  logic       acc, is_data, drop, complete, store;
  logic [7:0] byte_in, b0, b1, b2;
  logic       ovf;
  logic [8:0] dx9, dy9;

  assign in_ready_o = !q_full_i;
  assign acc        = in_valid_i && !q_full_i;
  assign is_data    = (cmd_e'(in_cmd_i) == CMD_DATA);
  assign byte_in    = in_data_i[7:0];

  // first byte must carry the always-one sync bit
  assign drop     = (idx_q == 2'd0) && !byte_in[3];
  assign complete = wheel_i ? (idx_q == 2'd3) : (idx_q >= 2'd2);
  assign store    = acc && is_data && !drop && (idx_q != 2'd3);

  assign b0 = bytes_q[0];
  assign b1 = bytes_q[1];
  assign b2 = (idx_q == 2'd2) ? byte_in : bytes_q[2];

  assign ovf = b0[7] | b0[6];
  assign dx9 = {b0[4], b1};
  assign dy9 = {b0[5], b2};

  always_comb begin
    job_o.kind  = is_data ? JOB_PACKET : JOB_SETPOS;
    job_o.set_x = in_data_i[23:8];
    job_o.set_y = in_data_i[39:24];
    job_o.rel_x = ovf ? 11'sd0 : {dx9, 2'b00};
    job_o.rel_y = ovf ? 11'sd0 : {dy9, 2'b00};
    job_o.rel_z = wheel_i ? byte_in[3:0] : 4'sd0;
    job_o.btn   = b0[2:0];
  end

  assign push_o = acc && (!is_data || (!drop && complete));

  always_comb begin
    idx_d = idx_q;
    if (acc && is_data && !drop) begin
      idx_d = complete ? 2'd0 : idx_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= 2'd0;
    end else begin
      idx_q <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store) begin
      bytes_q[idx_q] <= byte_in;
    end
  end

endmodule

### src/pmpd_fifo.sv
module pmpd_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  pmpd_pkg::job_t job_i,
  input  logic           pop_i,
  output pmpd_pkg::job_t job_o,
  output logic           full_o,
  output logic           empty_o
);
  import pmpd_pkg::*;

  localparam int unsigned PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned CntW = $clog2(QDepth + 1);

  job_t            mem_q [QDepth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o  = (cnt_q == CntW'(QDepth));
  assign empty_o = (cnt_q == '0);
  assign job_o   = mem_q[rd_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(QDepth - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(QDepth - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

endmodule

### src/pmpd_back.sv
module pmpd_back #(
  parameter int unsigned PB   = pmpd_pkg::PositionBits,
  parameter int unsigned ODW  = 72
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  pmpd_pkg::cfg_t cfg_i,
  input  pmpd_pkg::job_t job_i,
  input  logic           q_empty_i,
  output logic           pop_o,
  output logic           m_valid_o,
  input  logic           m_ready_i,
  output logic [ODW-1:0] m_data_o,
  output logic [1:0]     m_user_o,
  output logic           m_last_o
);
  import pmpd_pkg::*;

  localparam int unsigned CW = ((PB > 16) ? PB : 16) + 2;

  function automatic logic [PB-1:0] limit_of(input logic [12:0] size);
    logic [CW-1:0] s;
    logic [CW-1:0] cap;
    s   = CW'(size);
    cap = CW'(1) << PB;
    if (s == '0) s = CW'(1);
    if (s > cap) s = cap;
    s = s - CW'(1);
    return s[PB-1:0];
  endfunction

  function automatic logic [PB-1:0] clamp_to(input logic signed [CW-1:0] v,
                                             input logic [PB-1:0]        hi);
    if (v < 0) return '0;
    if (v > $signed({{(CW-PB){1'b0}}, hi})) return hi;
    return v[PB-1:0];
  endfunction

  logic [PB-1:0]      cur_x_q, cur_y_q, nxt_x, nxt_y, lim_x, lim_y;
  logic [15:0]        wheel_q;
  logic [2:0]         prev_btn_q;
  logic [3:0]         pend_q, pend_d, sel_mask, pend_rest;
  logic signed [10:0] ev_rx_q, ev_ry_q;
  logic signed [3:0]  ev_rz_q;
  logic [2:0]         ev_btn_q;
  logic               m_valid_q;
  logic [ODW-1:0]     m_data_q;
  logic [1:0]         m_user_q;
  logic               m_last_q;

  logic signed [CW-1:0] sum_x, sum_y, sx, sy;
  logic                 out_free, load, pop_pkt, pressed;
  action_e              sel;

  assign lim_x = limit_of(cfg_i.screen_width);
  assign lim_y = limit_of(cfg_i.screen_height);

  assign sum_x = $signed({{(CW-PB){1'b0}}, cur_x_q})
               + $signed({{(CW-11){job_i.rel_x[10]}}, job_i.rel_x});
  assign sum_y = $signed({{(CW-PB){1'b0}}, cur_y_q})
               - $signed({{(CW-11){job_i.rel_y[10]}}, job_i.rel_y});
  assign sx    = $signed({{(CW-16){job_i.set_x[15]}}, job_i.set_x});
  assign sy    = $signed({{(CW-16){job_i.set_y[15]}}, job_i.set_y});

  assign nxt_x = clamp_to((job_i.kind == JOB_SETPOS) ? sx : sum_x, lim_x);
  assign nxt_y = clamp_to((job_i.kind == JOB_SETPOS) ? sy : sum_y, lim_y);

  // lowest pending event goes first: motion, left, right, middle
  always_comb begin
    if (pend_q[0]) begin
      sel = ACT_MOTION;
    end else if (pend_q[1]) begin
      sel = ACT_LEFT;
    end else if (pend_q[2]) begin
      sel = ACT_RIGHT;
    end else begin
      sel = ACT_MIDDLE;
    end
  end

  assign sel_mask  = 4'b0001 << sel;
  assign pend_rest = pend_q & ~sel_mask;

  always_comb begin
    unique case (sel)
      ACT_MOTION: pressed = ev_btn_q[0];
      ACT_LEFT:   pressed = ev_btn_q[0];
      ACT_RIGHT:  pressed = ev_btn_q[1];
      default:    pressed = ev_btn_q[2];
    endcase
  end

  assign out_free = !m_valid_q || m_ready_i;
  assign load     = (pend_q != '0) && out_free;
  assign pop_o    = !q_empty_i && ((pend_q == '0) || (load && pend_rest == '0));
  assign pop_pkt  = pop_o && (job_i.kind == JOB_PACKET);

  always_comb begin
    pend_d = pend_q;
    if (pop_pkt) begin
      pend_d = {job_i.btn ^ prev_btn_q, 1'b1};
    end else if (load) begin
      pend_d = pend_rest;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_x_q    <= PB'(CursorXReset);
      cur_y_q    <= PB'(CursorYReset);
      wheel_q    <= '0;
      prev_btn_q <= '0;
      pend_q     <= '0;
      m_valid_q  <= 1'b0;
    end else begin
      pend_q <= pend_d;
      if (pop_o) begin
        cur_x_q <= nxt_x;
        cur_y_q <= nxt_y;
      end
      if (pop_pkt) begin
        wheel_q    <= wheel_q + {{12{job_i.rel_z[3]}}, job_i.rel_z};
        prev_btn_q <= job_i.btn;
      end
      if (load) begin
        m_valid_q <= 1'b1;
      end else if (m_ready_i) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_pkt) begin
      ev_rx_q  <= job_i.rel_x;
      ev_ry_q  <= job_i.rel_y;
      ev_rz_q  <= job_i.rel_z;
      ev_btn_q <= job_i.btn;
    end
    if (load) begin
      m_data_q <= ODW'({pressed, ev_btn_q, wheel_q, ev_rz_q, ev_ry_q, ev_rx_q,
                        cur_y_q, cur_x_q});
      m_user_q <= sel;
      m_last_q <= (pend_rest == '0);
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = m_data_q;
  assign m_user_o  = m_user_q;
  assign m_last_o  = m_last_q;

endmodule

### src/ps2_mouse_packet_decoder_top.sv
// PS/2 wheel-mouse packet decoder with cursor tracking.
// Input stream (s_axis): one beat is either a raw mouse byte (tuser = 0) or a
// set-cursor command (tuser = 1) carrying signed X/Y that get clamped to the
// screen. Bytes are gathered into 3- or 4-byte packets; a first byte without
// its sync bit is dropped.
// Output stream (m_axis): per complete packet one motion beat, then one beat
// per changed button (left, right, middle); tlast marks the packet's last beat.
// tuser carries the event kind.
// Front end takes one input beat per cycle while the queue has room and pushes
// decoded work into a 2-entry queue; the back end pops it, updates cursor and
// wheel, and emits one event per cycle, unless m_axis stalls, through a
// registered output stage; a packet's first event passes the queue, the
// pending-event register and the output register. A packet gives a motion event
// and one per changed button, a set-cursor command none; the back end's single
// event port sets the pace; the next job pops as a packet's last event loads.
// Output stall: the output holds its beat, the queue fills, then s_axis_tready
// drops. Reset: cursor 512/384, wheel 0, buttons 0, screen 1024x768,
// 3-byte packets; no clearing pass.
// Config port: cfg_we_i writes register cfg_idx_i (0 width, 1 height,
// 2 packet size) at the clock edge; write only while the block is idle.
`include "ps2_mouse_packet_decoder_top_macros.svh"

module ps2_mouse_packet_decoder_top #(
  parameter int unsigned PositionBits = pmpd_pkg::PositionBits,
  parameter int unsigned OutDataW     = ((2 * PositionBits + 46 + 7) / 8) * 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // stream in
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [pmpd_pkg::InDataW-1:0]  s_axis_tdata,  // data_byte, set_x, set_y
  input  logic [0:0]                    s_axis_tuser,  // cmd
  // stream out
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // pos_x, pos_y, rel_x, rel_y, rel_z, wheel_total, buttons, pressed, zero pad
  output logic [OutDataW-1:0]           m_axis_tdata,
  output logic [1:0]                    m_axis_tuser,  // action
  output logic                          m_axis_tlast,
  // configuration
  input  logic                          cfg_we_i,
  input  logic [pmpd_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [pmpd_pkg::CfgW-1:0]     cfg_data_i
);
  import pmpd_pkg::*;

  // bit positions inside m_axis_tdata
  localparam int unsigned BtnLsb     = 2 * PositionBits + 42;
  localparam int unsigned PressedBit = 2 * PositionBits + 45;

  cfg_t cfg_q;
  job_t front_job, q_job;
  logic push, pop, q_full, q_empty;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.screen_width  <= ResetWidth;
      cfg_q.screen_height <= ResetHeight;
      cfg_q.packet_size   <= ResetPktSize;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SCREEN_WIDTH:  cfg_q.screen_width  <= cfg_data_i;
        CFG_SCREEN_HEIGHT: cfg_q.screen_height <= cfg_data_i;
        CFG_PACKET_SIZE:   cfg_q.packet_size   <= cfg_data_i[2:0];
        default: ;  // unused index, ignored
      endcase
    end
  end

  // byte assembly and packet decode
  pmpd_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .in_cmd_i   (s_axis_tuser[0]),
    .in_data_i  (s_axis_tdata),
    .wheel_i    (cfg_q.packet_size >= PktSizeWheel),
    .q_full_i   (q_full),
    .push_o     (push),
    .job_o      (front_job)
  );

  // decouples decode from event emission
  pmpd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (front_job),
    .pop_i   (pop),
    .job_o   (q_job),
    .full_o  (q_full),
    .empty_o (q_empty)
  );

  // cursor/wheel update and event sequencing
  pmpd_back #(
    .PB  (PositionBits),
    .ODW (OutDataW)
  ) u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_i     (cfg_q),
    .job_i     (q_job),
    .q_empty_i (q_empty),
    .pop_o     (pop),
    .m_valid_o (m_axis_tvalid),
    .m_ready_i (m_axis_tready),
    .m_data_o  (m_axis_tdata),
    .m_user_o  (m_axis_tuser),
    .m_last_o  (m_axis_tlast)
  );

  // after a popped packet, tvalid is high past the pending and output registers
  `PMPD_ASSERT_NEXT(a_pkt_emits, pop && q_job.kind == JOB_PACKET, ##1 m_axis_tvalid)
  // motion beat's pressed bit mirrors the left button
  `PMPD_ASSERT_SAME(a_motion_pressed, m_axis_tvalid && m_axis_tuser == ACT_MOTION,
                    m_axis_tdata[PressedBit] == m_axis_tdata[BtnLsb])
  // middle-button beat is always the final one of its packet
  `PMPD_ASSERT_SAME(a_middle_last, m_axis_tvalid && !m_axis_tlast,
                    m_axis_tuser != ACT_MIDDLE)

endmodule

### sim/tb.sv
`timescale 1ns / 1ps

// Mouse packet decoder bench: stream bytes and cursor loads in, check the event stream out.
module tb;
  import pmpd_pkg::*;

  localparam int unsigned OutW       = ((2 * PositionBits + 46 + 7) / 8) * 8;
  localparam int unsigned PosSpan    = 1 << PositionBits;
  localparam int          CycleLimit = 300000;
  localparam int          NumPhases  = 10;
  localparam int          PhaseBeats = 42;

  // One decoded event as it leaves m_axis.
  typedef struct packed {
    logic [11:0]        pos_x;
    logic [11:0]        pos_y;
    logic signed [10:0] rel_x;
    logic signed [10:0] rel_y;
    logic signed [3:0]  rel_z;
    logic [15:0]        wheel;
    logic [2:0]         buttons;
    action_e            action;
    logic               pressed;
    logic               last;
  } ptr_event_t;

  // Directed stimulus row. Rows with hand_coded set carry the one motion event
  // they must produce (no buttons held, 3-byte packets).
  typedef struct {
    cmd_e               cmd;
    logic [7:0]         data;
    logic [15:0]        set_x;
    logic [15:0]        set_y;
    bit                 hand_coded;
    logic [11:0]        pos_x;
    logic [11:0]        pos_y;
    logic signed [10:0] rel_x;
    logic signed [10:0] rel_y;
  } stim_row_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata;   // data_byte, set_x, set_y
  logic [0:0]           s_axis_tuser;   // cmd
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  logic [OutW-1:0]      m_axis_tdata;   // pos_x, pos_y, rel_x, rel_y, rel_z, wheel, buttons, pressed
  logic [1:0]           m_axis_tuser;   // action
  logic                 m_axis_tlast;
  logic                 cfg_we_i;
  logic [CfgIdxW-1:0]   cfg_idx_i;
  logic [CfgW-1:0]      cfg_data_i;

  ps2_mouse_packet_decoder_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  // ---------------------------------------------------------------------------
  // Shadow copy of the decoder: config, packet assembly, cursor, wheel, buttons.
  // ---------------------------------------------------------------------------
  logic [12:0]  shadow_width;
  logic [12:0]  shadow_height;
  logic [2:0]   shadow_pkt_size;
  int unsigned  byte_slot;
  logic [7:0]   pkt_buf [3];
  int           shadow_x;
  int           shadow_y;
  logic [15:0]  wheel_sum;
  logic [2:0]   held_buttons;

  ptr_event_t expected_events [$];

  int  fail_count;
  int  cycle_count;
  bit  in_burst;
  bit  out_burst;

  stim_row_t directed_rows [26];

  function automatic void flag(input string msg);
    fail_count++;
    if (fail_count <= 10) $display("%s", msg);
  endfunction

  function automatic string event_str(input ptr_event_t e);
    return $sformatf("x=%0d y=%0d rx=%0d ry=%0d rz=%0d wheel=%0d btn=%0d act=%s pr=%0b last=%0b",
                     e.pos_x, e.pos_y, e.rel_x, e.rel_y, e.rel_z, $signed(e.wheel),
                     e.buttons, e.action.name(), e.pressed, e.last);
  endfunction

  // Per-beat wait on either side; now and then flip into a no-wait stretch.
  function automatic int draw_wait(inout bit burst);
    if ($urandom_range(0, 39) == 0) burst = !burst;
    return burst ? 0 : $urandom_range(0, 5);
  endfunction

  // Effective packet length: anything below 4 acts as 3.
  function automatic int unsigned pkt_len();
    return (shadow_pkt_size >= 3'd4) ? 4 : 3;
  endfunction

  // Clamp to [0, size-1]; size 0 acts as 1, sizes past the cursor range are capped.
  function automatic int clamp_axis(input int v, input logic [12:0] size);
    int hi;
    if (size == 13'd0) hi = 0;
    else if (int'(size) > PosSpan) hi = PosSpan - 1;
    else hi = int'(size) - 1;
    if (v < 0) v = 0;
    if (v > hi) v = hi;
    return v;
  endfunction

  function automatic logic [15:0] rand_coord();
    return $urandom_range(0, 1) ? 16'($urandom) : 16'($urandom_range(0, 4200));
  endfunction

  // Apply one accepted beat to the shadow state; queue its events unless the
  // caller supplies hand-coded ones.
  function automatic void decode_beat(input cmd_e c, input logic [7:0] b,
                                      input logic [15:0] sx, input logic [15:0] sy,
                                      input bit queue_events);
    ptr_event_t   ev;
    ptr_event_t   evs [$];
    logic [2:0]   btn;
    int           dx, dy, dz;
    int unsigned  len;

    if (c == CMD_SETPOS) begin
      shadow_x = clamp_axis(int'($signed(sx)), shadow_width);
      shadow_y = clamp_axis(int'($signed(sy)), shadow_height);
      return;
    end

    len = pkt_len();
    // first byte without the sync bit is thrown away
    if (byte_slot == 0 && !b[3]) return;

    if (byte_slot + 1 < len) begin
      if (byte_slot < 3) pkt_buf[byte_slot] = b;
      byte_slot++;
      return;
    end

    // this byte closes the packet (also when size dropped under the count)
    if (byte_slot < 3) pkt_buf[byte_slot] = b;
    byte_slot = 0;

    btn = pkt_buf[0][2:0];
    dx  = int'(pkt_buf[1]) - (pkt_buf[0][4] ? 256 : 0);
    dy  = int'(pkt_buf[2]) - (pkt_buf[0][5] ? 256 : 0);
    dx  = dx * 4;
    dy  = dy * 4;
    if (pkt_buf[0][7:6] != 2'b00) begin
      dx = 0;
      dy = 0;
    end
    dz = (len == 4) ? int'($signed(b[3:0])) : 0;

    shadow_x  = clamp_axis(shadow_x + dx, shadow_width);
    shadow_y  = clamp_axis(shadow_y - dy, shadow_height);
    wheel_sum = wheel_sum + 16'(dz);

    ev.pos_x   = 12'(shadow_x);
    ev.pos_y   = 12'(shadow_y);
    ev.rel_x   = 11'(dx);
    ev.rel_y   = 11'(dy);
    ev.rel_z   = 4'(dz);
    ev.wheel   = wheel_sum;
    ev.buttons = btn;
    ev.action  = ACT_MOTION;
    ev.pressed = btn[0];
    ev.last    = 1'b0;
    evs.push_back(ev);
    // then one event per changed button: left, right, middle
    for (int i = 0; i < 3; i++) begin
      if (btn[i] != held_buttons[i]) begin
        ev.action  = action_e'(i + 1);
        ev.pressed = btn[i];
        evs.push_back(ev);
      end
    end
    evs[evs.size() - 1].last = 1'b1;
    held_buttons = btn;

    if (queue_events) foreach (evs[i]) expected_events.push_back(evs[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // Input side. Beats are driven right after a rising edge; tready is sampled
  // at the falling edge, where it is stable for the next rising edge.
  // ---------------------------------------------------------------------------
  task automatic send_beat(input cmd_e c, input logic [7:0] b, input logic [15:0] sx,
                           input logic [15:0] sy, input bit queue_events);
    int gap;
    bit took;
    gap = draw_wait(in_burst);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {sy, sx, b};
    s_axis_tuser  <= c;
    do begin
      @(negedge clk_i);
      took = s_axis_tready;
      @(posedge clk_i);
    end while (!took);
    decode_beat(c, b, sx, sy, queue_events);
  endtask

  // Quiet the input and let the decoder drain; trailing cursor loads and
  // partial bytes make no event, so keep clocking after the last event arrives.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_events.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [12:0] w, input logic [12:0] h,
                              input logic [12:0] sz);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_SCREEN_WIDTH;
    cfg_data_i <= w;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_SCREEN_HEIGHT;
    cfg_data_i <= h;
    @(posedge clk_i);
    cfg_idx_i  <= CFG_PACKET_SIZE;
    cfg_data_i <= sz;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    shadow_width    = w;
    shadow_height   = h;
    shadow_pkt_size = sz[2:0];
  endtask

  // ---------------------------------------------------------------------------
  // Clock, cycle count and watchdog.
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial cycle_count = 0;
  always @(posedge clk_i) cycle_count <= cycle_count + 1;

  initial begin
    wait (cycle_count >= CycleLimit);
    $display("** ps2_mouse_packet_decoder_top: FAILED **");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Output side: random backpressure, every accepted beat checked in order.
  // ---------------------------------------------------------------------------
  initial begin
    ptr_event_t   seen;
    ptr_event_t   want;
    bit           got;
    int           gap;
    m_axis_tready = 1'b0;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      gap = draw_wait(out_burst);
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do begin
        @(negedge clk_i);
        got           = m_axis_tvalid;
        seen.pos_x    = m_axis_tdata[11:0];
        seen.pos_y    = m_axis_tdata[23:12];
        seen.rel_x    = m_axis_tdata[34:24];
        seen.rel_y    = m_axis_tdata[45:35];
        seen.rel_z    = m_axis_tdata[49:46];
        seen.wheel    = m_axis_tdata[65:50];
        seen.buttons  = m_axis_tdata[68:66];
        seen.pressed  = m_axis_tdata[69];
        seen.action   = action_e'(m_axis_tuser);
        seen.last     = m_axis_tlast;
        @(posedge clk_i);
      end while (!got);
      if (expected_events.size() == 0) begin
        flag($sformatf("cycle %0d: event with none pending: %s", cycle_count, event_str(seen)));
      end else begin
        want = expected_events.pop_front();
        if (seen !== want)
          flag($sformatf("cycle %0d: event mismatch\n  exp %s\n  got %s",
                         cycle_count, event_str(want), event_str(seen)));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------
  initial begin
    int          fed;
    int          roll;
    logic [7:0]  hdr;
    logic [12:0] w, h, sz;
    ptr_event_t  ev;

    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_SCREEN_WIDTH;
    cfg_data_i    = '0;
    fail_count    = 0;
    in_burst      = 1'b0;
    out_burst     = 1'b0;

    shadow_width    = ResetWidth;
    shadow_height   = ResetHeight;
    shadow_pkt_size = ResetPktSize;
    byte_slot       = 0;
    shadow_x        = CursorXReset;
    shadow_y        = CursorYReset;
    wheel_sum       = '0;
    held_buttons    = '0;

    // Directed part, at reset config (1024x768, 3-byte packets).
    directed_rows = '{
      // idle packet straight after reset: cursor at its reset spot
      '{CMD_DATA,   8'h08, 16'h0000, 16'h0000, 1'b0, 12'd0,    12'd0,   11'd0,   11'd0},
      '{CMD_DATA,   8'h00, 16'h0000, 16'h0000, 1'b0, 12'd0,    12'd0,   11'd0,   11'd0},
      '{CMD_DATA,   8'h00, 16'h0000, 16'h0000, 1'b1, 12'd512,  12'd384, 11'd0,   11'd0},
      // no sync bit: dropped
      '{CMD_DATA,   8'h00, 16'h0000, 16'h0000, 1'b0, 12'd0,    12'd0,   11'd0,   11'd0},
      '{CMD_DATA,   8'hF7, 16'h0000, 16'h0000, 1'b0, 12'd0,    12'd0,   11'd0,   11'd0},
      // cursor load far past the screen clamps to the corner
      '{CMD_SETPOS, 8'hFF, 16'h7FFF, 16'h7FFF, 1'b0, 12'd0,    12'd0,   11'd0,   11'd0},
      // largest positive deltas: x stays clamped, y (inverted) hits 0
      '{CMD_DATA,   8'h08, 16'h0000, 16'h0000, 1'b0, 12'd0,    12'd0,   11'd0,   11'd0},
      '{CMD_DATA,   8'hFF, 16'h0000, 16'h0000, 1'b0, 12'd0,    12'd0,   11'd0,   11'd0},
      '{CMD_DATA,   8'hFF, 16'h0000, 16'h0000, 1'b1, 12'd1023, 12'd0,   11'd1020, 11'd1020},
      // most negative cursor load
      '{CMD_SETPOS, 8'h00, 16'h8000, 16'h8000, 1'b0, 12'd0,    12'd0,   11'd0,   11'd0},
      // most negative deltas
      '{CMD_DATA,   8'h38, 16'h0000, 16'h0000, 1'b0, 12'd0,    12'd0,   11'd0,   11'd0},
      '{CMD_DATA,   8'h00, 16'h0000, 16'h0000, 1'b0, 12'd0,    12'd0,   11'd0,   11'd0},
      '{CMD_DATA,   8'h00, 16'h0000, 16'h0000, 1'b1, 12'd0,    12'd767, 11'h400, 11'h400},
      // both overflow bits: deltas forced to zero
      '{CMD_DATA,   8'hF8, 16'h0000, 16'h0000, 1'b0, 12'd0,    12'd0,   11'd0,   11'd0},
      '{CMD_DATA,   8'hFF, 16'h0000, 16'h0000, 1'b0, 12'd0,    12'd0,   11'd0,   11'd0},
      '{CMD_DATA,   8'hFF, 16'h0000, 16'h0000, 1'b1, 12'd0,    12'd767, 11'd0,   11'd0},
      // all three buttons down: motion plus three button events
      '{CMD_DATA,   8'h0F, 16'h0000, 16'h0000, 1'b0, 12'd0,    12'd0,   11'd0,   11'd0},
      '{CMD_DATA,   8'h01, 16'h0000, 16'h0000, 1'b0, 12'd0,    12'd0,   11'd0,   11'd0},
      '{CMD_DATA,   8'h01, 16'h0000, 16'h0000, 1'b0, 12'd0,    12'd0,   11'd0,   11'd0},
      // in-range cursor load
      '{CMD_SETPOS, 8'h5A, 16'd100,  16'd200,  1'b0, 12'd0,    12'd0,   11'd0,   11'd0},
      // all released
      '{CMD_DATA,   8'h08, 16'h0000, 16'h0000, 1'b0, 12'd0,    12'd0,   11'd0,   11'd0},
      '{CMD_DATA,   8'h00, 16'h0000, 16'h0000, 1'b0, 12'd0,    12'd0,   11'd0,   11'd0},
      '{CMD_DATA,   8'h00, 16'h0000, 16'h0000, 1'b0, 12'd0,    12'd0,   11'd0,   11'd0},
      // one overflow bit, left + middle pressed
      '{CMD_DATA,   8'h4D, 16'h0000, 16'h0000, 1'b0, 12'd0,    12'd0,   11'd0,   11'd0},
      '{CMD_DATA,   8'h10, 16'h0000, 16'h0000, 1'b0, 12'd0,    12'd0,   11'd0,   11'd0},
      '{CMD_DATA,   8'h10, 16'h0000, 16'h0000, 1'b0, 12'd0,    12'd0,   11'd0,   11'd0}
    };

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[r]) begin
      send_beat(directed_rows[r].cmd, directed_rows[r].data, directed_rows[r].set_x,
                directed_rows[r].set_y, !directed_rows[r].hand_coded);
      if (directed_rows[r].hand_coded) begin
        ev.pos_x   = directed_rows[r].pos_x;
        ev.pos_y   = directed_rows[r].pos_y;
        ev.rel_x   = directed_rows[r].rel_x;
        ev.rel_y   = directed_rows[r].rel_y;
        ev.rel_z   = '0;
        ev.wheel   = '0;
        ev.buttons = '0;
        ev.action  = ACT_MOTION;
        ev.pressed = 1'b0;
        ev.last    = 1'b1;
        expected_events.push_back(ev);
      end
    end
    settle();

    // Random phases, each under its own config. Each phase ends one byte short
    // of a packet, so the next config (size change included) lands mid-packet.
    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0:       begin w = 13'd1024; h = 13'd768;  sz = 13'd4;    end
        1:       begin w = 13'd0;    h = 13'd0;    sz = 13'd3;    end
        2:       begin w = 13'd1;    h = 13'd1;    sz = 13'd4;    end
        3:       begin w = 13'd4096; h = 13'd4096; sz = 13'd7;    end
        4:       begin w = 13'h1FFF; h = 13'h1FFF; sz = 13'h1FF8; end  // size bits 0 -> 3
        5:       begin w = 13'd4097; h = 13'd2;    sz = 13'h1FFD; end  // size bits 5 -> 4
        default: begin
          w  = $urandom_range(0, 3) == 0 ? 13'($urandom) : 13'($urandom_range(1, 4096));
          h  = $urandom_range(0, 3) == 0 ? 13'($urandom) : 13'($urandom_range(1, 4096));
          sz = 13'($urandom_range(0, 7));
        end
      endcase
      write_config(w, h, sz);

      fed = 0;
      while (fed < PhaseBeats) begin
        roll = $urandom_range(0, 99);
        if (roll < 10) begin
          send_beat(CMD_SETPOS, 8'($urandom), rand_coord(), rand_coord(), 1'b1);
          fed++;
        end else if (roll < 18) begin
          // stray byte: may be dropped or knock the framing off
          send_beat(CMD_DATA, 8'($urandom), 16'($urandom), 16'($urandom), 1'b1);
        end else begin
          hdr = 8'($urandom) | 8'h08;
          if ($urandom_range(0, 7) != 0) hdr[7:6] = 2'b00;
          send_beat(CMD_DATA, hdr, 16'($urandom), 16'($urandom), 1'b1);
          for (int k = 1; k < pkt_len(); k++)
            send_beat(CMD_DATA, 8'($urandom), 16'($urandom), 16'($urandom), 1'b1);
          fed += pkt_len();
        end
      end

      hdr = 8'($urandom) | 8'h08;
      send_beat(CMD_DATA, hdr, 16'($urandom), 16'($urandom), 1'b1);
      for (int k = 2; k < pkt_len(); k++)
        send_beat(CMD_DATA, 8'($urandom), 16'($urandom), 16'($urandom), 1'b1);
      settle();
    end

    // finish the dangling packet, then drain with extra margin
    for (int k = 0; k < 4; k++)
      send_beat(CMD_DATA, 8'h08, 16'h0000, 16'h0000, 1'b1);
    settle();
    repeat (20) @(posedge clk_i);

    if (expected_events.size() != 0)
      flag($sformatf("%0d events never arrived", expected_events.size()));

    if (fail_count == 0) begin
      $display("** ps2_mouse_packet_decoder_top: PASSED **");
    end else begin
      $display("** ps2_mouse_packet_decoder_top: FAILED **");
    end
    $finish;
  end

endmodule
